// ===== sv/zroc_pkg.sv =====
// ----------------------------------------------------------------------------
// zroc_pkg
// Shared types and constants for the z-ordered rectangle occlusion filter:
// default sizes, register map, register reset values and result codes.
// ----------------------------------------------------------------------------
package zroc_pkg;

   localparam int MAX_RECTS_DEF  = 64;
   localparam int COORD_BITS_DEF = 16;

   // Register widths and port sizes
   localparam int MIN_EXT_W    = 11;
   localparam int LOW_LIMIT_W  = 16;
   localparam int HIGH_LIMIT_W = 15;
   localparam int INSET_W      = 7;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic        [MIN_EXT_W-1:0]    MIN_EXT_RST    = 11'd24;
   localparam logic signed [LOW_LIMIT_W-1:0]  LOW_LIMIT_RST  = -16'sd10000;
   localparam logic        [HIGH_LIMIT_W-1:0] HIGH_LIMIT_RST = 15'd30000;
   localparam logic        [INSET_W-1:0]      INSET_RST      = 7'd4;

   typedef enum logic [1:0] {
      REG_MIN_EXTENT  = 2'd0,
      REG_COORD_LOW   = 2'd1,
      REG_COORD_HIGH  = 2'd2,
      REG_PROBE_INSET = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OUT_VISIBLE     = 2'd0,
      OUT_TOO_SMALL   = 2'd1,
      OUT_OFF_DESKTOP = 2'd2,
      OUT_OCCLUDED    = 2'd3
   } outcome_type;

endpackage

// ===== sv/zorder_rect_occlusion_filter.sv =====
// ----------------------------------------------------------------------------
// zorder_rect_occlusion_filter
// Classifies front-to-back rectangles as too small, off desktop, occluded by
// earlier stored rectangles, or visible; keeps accepted ones in a store while it has room.
// ----------------------------------------------------------------------------
// Sequence: a request is taken in ST_IDLE and checked in ST_CHECK; a rejected
// rectangle goes to ST_FINISH, an accepted one first scans the store in ST_SCAN.
// Throughput: one transaction at a time; the next is taken the cycle after the
// result loads. The scan of the store goes through its single read port
// (one entry, three probes a cycle).
// Reset: synchronous; empties the store, loads register defaults, no clearing pass.
module zorder_rect_occlusion_filter #(
   parameter int MAX_RECTS  = zroc_pkg::MAX_RECTS_DEF,
   parameter int COORD_BITS = zroc_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_new_snapshot,
   input  logic signed [COORD_BITS-1:0]          req_left_edge,
   input  logic signed [COORD_BITS-1:0]          req_top_edge,
   input  logic signed [COORD_BITS-1:0]          req_right_edge,
   input  logic signed [COORD_BITS-1:0]          req_bottom_edge,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_outcome,
   output logic                                  rsp_store_full,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [zroc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [zroc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [zroc_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   localparam int CW    = COORD_BITS;
   localparam int PW    = CW + 1;                     // probe coordinates
   localparam int EW    = ((CW > 17) ? CW : 17) + 2;  // extent and limit checks
   localparam int CNT_W = $clog2(MAX_RECTS + 1);
   localparam int IDX_W = $clog2(MAX_RECTS);
   localparam int ENT_W = 4 * CW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // control
   state_type                         state_ff, state_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                              rd_vld_ff, rd_vld_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   zroc_pkg::outcome_type             rsp_outcome_ff, rsp_outcome_in;
   logic                              rsp_full_ff, rsp_full_in;
   logic [zroc_pkg::MIN_EXT_W-1:0]    min_ext_ff, min_ext_in;
   logic signed [zroc_pkg::LOW_LIMIT_W-1:0] low_ff, low_in;
   logic [zroc_pkg::HIGH_LIMIT_W-1:0] high_ff, high_in;
   logic [zroc_pkg::INSET_W-1:0]      inset_ff, inset_in;

   // payload
   logic signed [CW-1:0]              l_ff, l_in, t_ff, t_in, r_ff, r_in, b_ff, b_in;
   logic signed [PW-1:0]              px0_ff, px0_in, px1_ff, px1_in, px2_ff, px2_in;
   logic signed [PW-1:0]              py_ff, py_in;
   logic [CNT_W-1:0]                  iss_ff, iss_in;
   logic [2:0]                        cov_ff, cov_in;
   zroc_pkg::outcome_type             res_ff, res_in;
   logic                              keep_ff, keep_in;

   // store
   logic [ENT_W-1:0]                  mem [MAX_RECTS];
   logic [ENT_W-1:0]                  rd_data_ff;
   logic                              mem_re, mem_we;

   // datapath for the check cycle
   logic signed [EW-1:0] l_e, t_e, r_e, b_e, wid, hgt, me_e, low_e, high_e, inset_e;
   logic signed [EW-1:0] q_e, qadj_e, half_e;
   logic [zroc_pkg::MIN_EXT_W-1:0] me_u;
   logic                 too_small, off_desk, has_room, out_free, csr_wr;
   logic [2:0]           hit;
   zroc_pkg::reg_index_type csr_idx;

   function automatic logic probe_hit(input logic signed [PW-1:0] x,
                                      input logic signed [PW-1:0] y,
                                      input logic [ENT_W-1:0]     e);
      logic signed [PW-1:0] el, et, er, eb;
      el = PW'($signed(e[4*CW-1 -: CW]));
      et = PW'($signed(e[3*CW-1 -: CW]));
      er = PW'($signed(e[2*CW-1 -: CW]));
      eb = PW'($signed(e[CW-1 -: CW]));
      return (x >= el) && (x <= er) && (y >= et) && (y <= eb);
   endfunction

   assign pready         = 1'b1;
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_outcome    = rsp_outcome_ff;
   assign rsp_store_full = rsp_full_ff;

   assign csr_idx  = zroc_pkg::reg_index_type'(paddr[3:2]);
   assign csr_wr   = psel && penable && pwrite;
   assign has_room = (cnt_ff < CNT_W'(MAX_RECTS));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (csr_idx)
         zroc_pkg::REG_MIN_EXTENT:  prdata = zroc_pkg::CSR_DATA_W'(min_ext_ff);
         zroc_pkg::REG_COORD_LOW:   prdata = zroc_pkg::CSR_DATA_W'(low_ff);
         zroc_pkg::REG_COORD_HIGH:  prdata = zroc_pkg::CSR_DATA_W'(high_ff);
         zroc_pkg::REG_PROBE_INSET: prdata = zroc_pkg::CSR_DATA_W'(inset_ff);
      endcase
   end

   // extent, limit and probe arithmetic on the held rectangle
   always_comb begin
      l_e     = EW'(l_ff);
      t_e     = EW'(t_ff);
      r_e     = EW'(r_ff);
      b_e     = EW'(b_ff);
      me_u    = (min_ext_ff == '0) ? zroc_pkg::MIN_EXT_W'(1) : min_ext_ff;
      me_e    = $signed(EW'(me_u));
      low_e   = EW'(low_ff);
      high_e  = $signed(EW'(high_ff));
      inset_e = $signed(EW'(inset_ff));
      wid     = r_e - l_e + EW'(1);
      hgt     = b_e - t_e + EW'(1);
      too_small = (wid < me_e) || (hgt < me_e);
      off_desk  = (l_e < low_e) || (t_e < low_e) || (r_e > high_e) || (b_e > high_e);
      q_e     = l_e + r_e;
      // round the midpoint toward zero
      qadj_e  = q_e + (q_e[EW-1] ? EW'(1) : EW'(0));
      half_e  = qadj_e >>> 1;
   end

   always_comb begin
      hit[0] = probe_hit(px0_ff, py_ff, rd_data_ff);
      hit[1] = probe_hit(px1_ff, py_ff, rd_data_ff);
      hit[2] = probe_hit(px2_ff, py_ff, rd_data_ff);
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rd_vld_in      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_full_in    = rsp_full_ff;
      min_ext_in     = min_ext_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      inset_in       = inset_ff;
      l_in           = l_ff;
      t_in           = t_ff;
      r_in           = r_ff;
      b_in           = b_ff;
      px0_in         = px0_ff;
      px1_in         = px1_ff;
      px2_in         = px2_ff;
      py_in          = py_ff;
      iss_in         = iss_ff;
      cov_in         = cov_ff;
      res_in         = res_ff;
      keep_in        = keep_ff;
      mem_re         = 1'b0;
      mem_we         = 1'b0;

      if (csr_wr) begin
         unique case (csr_idx)
            zroc_pkg::REG_MIN_EXTENT:  min_ext_in = pwdata[zroc_pkg::MIN_EXT_W-1:0];
            zroc_pkg::REG_COORD_LOW:   low_in     = $signed(pwdata[zroc_pkg::LOW_LIMIT_W-1:0]);
            zroc_pkg::REG_COORD_HIGH:  high_in    = pwdata[zroc_pkg::HIGH_LIMIT_W-1:0];
            zroc_pkg::REG_PROBE_INSET: inset_in   = pwdata[zroc_pkg::INSET_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               l_in     = req_left_edge;
               t_in     = req_top_edge;
               r_in     = req_right_edge;
               b_in     = req_bottom_edge;
               cnt_in   = req_new_snapshot ? '0 : cnt_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            px0_in = PW'(l_e + inset_e);
            px1_in = PW'(half_e);
            px2_in = PW'(r_e - inset_e);
            py_in  = PW'(t_e + inset_e);
            iss_in = '0;
            cov_in = '0;
            priority if (too_small) begin
               res_in   = zroc_pkg::OUT_TOO_SMALL;
               keep_in  = 1'b0;
               state_in = ST_FINISH;
            end else if (off_desk) begin
               res_in   = zroc_pkg::OUT_OFF_DESKTOP;
               keep_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               keep_in  = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one store read a cycle, test the entry read the cycle before
            mem_re    = (iss_ff < cnt_ff);
            rd_vld_in = mem_re;
            if (mem_re) begin
               iss_in = iss_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               cov_in = cov_ff | hit;
            end
            if (!mem_re && !rd_vld_ff) begin
               res_in   = (&cov_ff) ? zroc_pkg::OUT_OCCLUDED : zroc_pkg::OUT_VISIBLE;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_ff;
               rsp_full_in    = keep_ff && !has_room;
               mem_we         = keep_ff && has_room;
               if (keep_ff && has_room) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_outcome_ff <= zroc_pkg::OUT_VISIBLE;
         rsp_full_ff    <= 1'b0;
         min_ext_ff     <= zroc_pkg::MIN_EXT_RST;
         low_ff         <= zroc_pkg::LOW_LIMIT_RST;
         high_ff        <= zroc_pkg::HIGH_LIMIT_RST;
         inset_ff       <= zroc_pkg::INSET_RST;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_full_ff    <= rsp_full_in;
         min_ext_ff     <= min_ext_in;
         low_ff         <= low_in;
         high_ff        <= high_in;
         inset_ff       <= inset_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff    <= l_in;
      t_ff    <= t_in;
      r_ff    <= r_in;
      b_ff    <= b_in;
      px0_ff  <= px0_in;
      px1_ff  <= px1_in;
      px2_ff  <= px2_in;
      py_ff   <= py_in;
      iss_ff  <= iss_in;
      cov_ff  <= cov_in;
      res_ff  <= res_in;
      keep_ff <= keep_in;
   end

   // rectangle store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[IDX_W-1:0]] <= {l_ff, t_ff, r_ff, b_ff};
      end
      if (mem_re) begin
         rd_data_ff <= mem[iss_ff[IDX_W-1:0]];
      end
   end

endmodule

// ===== sv/zroc_checker.sv =====
// ----------------------------------------------------------------------------
// zroc_checker
// Port-level checks for the occlusion filter: response hold, reject codes,
// and the number of transactions in flight.
// ----------------------------------------------------------------------------
module zroc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_outcome,
   input logic       rsp_store_full
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + (req_acc ? 2'd1 : 2'd0) - (rsp_acc ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome) && $stable(rsp_store_full))
      else $error("stalled response changed");

   a_reject_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == zroc_pkg::OUT_TOO_SMALL ||
                    rsp_outcome == zroc_pkg::OUT_OFF_DESKTOP) |-> !rsp_store_full)
      else $error("rejected rectangle flagged as store full");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != 2'd3) && (!rsp_valid || pend_ff != 2'd0))
      else $error("response without a matching request, or too many in flight");

endmodule

bind zorder_rect_occlusion_filter zroc_checker u_zroc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_outcome    (rsp_outcome),
   .rsp_store_full (rsp_store_full)
);
